/* hdl/dlt_pkg.sv */
`default_nettype none
package dlt_pkg;

  localparam int IFACE_W = 4;
  localparam int TIME_W  = 33;
  localparam int NOW_W   = 32;
  localparam int MASK_W  = 9;
  localparam int GUARD_W = 8;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [MASK_W-1:0]  MASK_RESET  = 9'h1FF;
  localparam logic [GUARD_W-1:0] GUARD_RESET = 8'd60;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] CFG_IFACE_MASK = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GUARD_SECS = 1'b1;

  typedef enum logic [1:0] {
    CMD_REQUEST  = 2'd0,
    CMD_RELEASE  = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_EXCHANGE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_INVALID_IFACE = 3'd1,
    ST_ASSIGNING     = 3'd2,
    ST_ALREADY       = 3'd3,
    ST_NOT_ASSIGNED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_DISCOVER    = 3'd1,
    ACT_UNICAST_REQ = 3'd2,
    ACT_BCAST_REQ   = 3'd3,
    ACT_RELEASE     = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    LS_INIT      = 2'd0,
    LS_RENEWING  = 2'd1,
    LS_REBINDING = 2'd2,
    LS_BOUND     = 2'd3
  } lease_state_t;

  typedef enum logic [1:0] {
    AS_NONE      = 2'd0,
    AS_ASSIGNING = 2'd1,
    AS_ASSIGNED  = 2'd2
  } assign_t;

  // One table entry; the all-zero word is the reset value of an entry.
  typedef struct packed {
    assign_t             assign_status;
    lease_state_t        lease_state;
    logic [TIME_W-1:0]   next_due;
    logic [TIME_W-1:0]   rebind_time;
    logic [TIME_W-1:0]   expire_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [TIME_W-1:0] next_deadline;
    lease_state_t      client_state;
    action_t           action;
    status_t           status_code;
  } result_t;

endpackage
`default_nettype wire

/* hdl/dlt_ram.sv */
`default_nettype none
module dlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/dlt_update.sv */
`default_nettype none
module dlt_update (
  input  wire dlt_pkg::cmd_t                  cmd,
  input  wire logic [dlt_pkg::NOW_W-1:0]      now_secs,
  input  wire logic [dlt_pkg::NOW_W-1:0]      lease_secs,
  input  wire logic                           exchange_ok,
  input  wire logic                           in_range,
  input  wire logic                           present,
  input  wire logic [dlt_pkg::GUARD_W-1:0]    guard_secs,
  input  wire dlt_pkg::entry_t                ent_i,
  output dlt_pkg::entry_t                     ent_o,
  output logic                                we_o,
  output dlt_pkg::result_t                    res_o
);

  localparam int TW = dlt_pkg::TIME_W;

  logic [TW-1:0]   now_ext;
  logic [TW-1:0]   diff_rb;
  logic [TW-1:0]   diff_ex;
  logic [TW-1:0]   half_rb;
  logic [TW-1:0]   half_ex;
  logic [TW:0]     guard_sum;
  logic            rb_far;
  logic            ex_far;
  logic            due;
  logic [TW+1:0]   lease7;
  logic [TW-1:0]   nb_next;
  logic [TW-1:0]   nb_rebind;
  logic [TW-1:0]   nb_expire;
  logic            invalid;

  assign now_ext = {1'b0, now_secs};

  // Halfway points; a deadline already passed collapses to now.
  assign diff_rb = (ent_i.rebind_time > now_ext) ? ent_i.rebind_time - now_ext : '0;
  assign diff_ex = (ent_i.expire_time > now_ext) ? ent_i.expire_time - now_ext : '0;
  assign half_rb = now_ext + (diff_rb >> 1);
  assign half_ex = now_ext + (diff_ex >> 1);

  assign guard_sum = {1'b0, now_ext} + (TW+1)'(guard_secs);
  assign rb_far    = guard_sum < {1'b0, ent_i.rebind_time};
  assign ex_far    = guard_sum < {1'b0, ent_i.expire_time};
  assign due       = now_ext >= ent_i.next_due;

  // Both operands are below 2^32, so the sums fit in 33 bits.
  assign lease7    = ({3'b000, lease_secs} << 3) - {3'b000, lease_secs};
  assign nb_next   = now_ext + TW'(lease_secs >> 1);
  assign nb_rebind = now_ext + TW'(lease7 >> 3);
  assign nb_expire = now_ext + {1'b0, lease_secs};

  always_comb begin
    ent_o   = ent_i;
    we_o    = 1'b0;
    invalid = 1'b0;
    res_o.status_code = dlt_pkg::ST_OK;
    res_o.action      = dlt_pkg::ACT_NONE;

    if (!in_range) begin
      invalid = 1'b1;
    end else begin
      unique case (cmd)
        dlt_pkg::CMD_REQUEST: begin
          priority if (!present) begin
            invalid = 1'b1;
          end else if (ent_i.assign_status == dlt_pkg::AS_ASSIGNING) begin
            res_o.status_code = dlt_pkg::ST_ASSIGNING;
          end else if (ent_i.assign_status == dlt_pkg::AS_ASSIGNED) begin
            res_o.status_code = dlt_pkg::ST_ALREADY;
          end else begin
            ent_o.assign_status = dlt_pkg::AS_ASSIGNING;
            ent_o.lease_state   = dlt_pkg::LS_INIT;
            ent_o.next_due      = '0;
            res_o.action        = dlt_pkg::ACT_DISCOVER;
            we_o                = 1'b1;
          end
        end
        dlt_pkg::CMD_RELEASE: begin
          priority if (!present) begin
            invalid = 1'b1;
          end else if (ent_i.assign_status == dlt_pkg::AS_NONE) begin
            res_o.status_code = dlt_pkg::ST_NOT_ASSIGNED;
          end else if (ent_i.assign_status == dlt_pkg::AS_ASSIGNING) begin
            res_o.status_code = dlt_pkg::ST_ASSIGNING;
          end else begin
            ent_o        = '0;
            res_o.action = dlt_pkg::ACT_RELEASE;
            we_o         = 1'b1;
          end
        end
        dlt_pkg::CMD_TICK: begin
          priority if (ent_i.assign_status == dlt_pkg::AS_NONE) begin
            res_o.status_code = dlt_pkg::ST_NOT_ASSIGNED;
          end else if (ent_i.lease_state != dlt_pkg::LS_INIT && due) begin
            we_o = 1'b1;
            unique case (ent_i.lease_state)
              dlt_pkg::LS_BOUND: begin
                ent_o.lease_state = dlt_pkg::LS_RENEWING;
                ent_o.next_due    = half_rb;
                res_o.action      = dlt_pkg::ACT_UNICAST_REQ;
              end
              dlt_pkg::LS_RENEWING: begin
                if (rb_far) begin
                  ent_o.next_due = half_rb;
                  res_o.action   = dlt_pkg::ACT_UNICAST_REQ;
                end else begin
                  ent_o.lease_state = dlt_pkg::LS_REBINDING;
                  ent_o.next_due    = half_ex;
                  res_o.action      = dlt_pkg::ACT_BCAST_REQ;
                end
              end
              default: begin
                if (ex_far) begin
                  ent_o.next_due = half_ex;
                  res_o.action   = dlt_pkg::ACT_BCAST_REQ;
                end else begin
                  ent_o.lease_state = dlt_pkg::LS_INIT;
                  ent_o.next_due    = now_ext;
                  res_o.action      = dlt_pkg::ACT_DISCOVER;
                end
              end
            endcase
          end else begin
            we_o = 1'b0;
          end
        end
        dlt_pkg::CMD_EXCHANGE: begin
          priority if (ent_i.assign_status == dlt_pkg::AS_NONE) begin
            res_o.status_code = dlt_pkg::ST_NOT_ASSIGNED;
          end else if (exchange_ok && ent_i.lease_state != dlt_pkg::LS_BOUND) begin
            ent_o.next_due      = nb_next;
            ent_o.rebind_time   = nb_rebind;
            ent_o.expire_time   = nb_expire;
            ent_o.lease_state   = dlt_pkg::LS_BOUND;
            ent_o.assign_status = dlt_pkg::AS_ASSIGNED;
            we_o                = 1'b1;
          end else begin
            we_o = 1'b0;
          end
        end
        default: begin
          we_o = 1'b0;
        end
      endcase
    end

    if (invalid) begin
      res_o.status_code   = dlt_pkg::ST_INVALID_IFACE;
      res_o.action        = dlt_pkg::ACT_NONE;
      res_o.client_state  = dlt_pkg::LS_INIT;
      res_o.next_deadline = '0;
    end else begin
      res_o.client_state  = ent_o.lease_state;
      res_o.next_deadline = ent_o.next_due;
    end
  end

endmodule
`default_nettype wire

/* hdl/dhcp_lease_timer_table.sv */
// Flow: a word accepted at one clock edge has its table read issued at that edge;
// the entry update and result capture take place in the update step, which waits
// while the result register still holds an undrained word.
// The next word is taken only once the read-modify-write of the entry table has
// finished; it may be taken while a result still waits.
// Reset (rst_n low, synchronous): clears the entry valid bits, so every entry
// reads as not assigned with zero deadlines at once, and loads the mask and guard.
`default_nettype none
module dhcp_lease_timer_table #(
  parameter int NUM_IFACES = 9
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input words.
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // tdata from bit 0: iface[3:0], now_secs[35:4], lease_secs[67:36],
  // exchange_ok[68], zero fill [71:69]
  input  wire logic [71:0]                      in_tdata,
  // tuser: cmd[1:0]
  input  wire logic [1:0]                       in_tuser,
  // Result words.
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // tdata from bit 0: status_code[2:0], action[5:3], client_state[7:6],
  // next_deadline[40:8], zero fill [47:41]
  output logic [47:0]                           out_tdata,
  // Configuration writes.
  input  wire logic                             cfg_we,
  input  wire logic [dlt_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [dlt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int IDX_W   = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
  localparam int MASK_EXT = 1 << dlt_pkg::IFACE_W;

  // Two-step sequencer: IDLE waits for a word and issues the table read,
  // EXEC updates the entry and hands the result to the output register.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                          state_r, state_nxt;
  logic [NUM_IFACES-1:0]           valid_r, valid_nxt;
  logic [dlt_pkg::MASK_W-1:0]      mask_r, mask_nxt;
  logic [dlt_pkg::GUARD_W-1:0]     guard_r, guard_nxt;
  logic                            out_valid_r, out_valid_nxt;
  dlt_pkg::result_t                out_data_r, out_data_nxt;

  // Fields of the word in flight, captured on accept.
  dlt_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [dlt_pkg::IFACE_W-1:0]     iface_r, iface_nxt;
  logic [dlt_pkg::NOW_W-1:0]       now_r, now_nxt;
  logic [dlt_pkg::NOW_W-1:0]       lease_r, lease_nxt;
  logic                            ok_r, ok_nxt;
  logic                            in_range_r, in_range_nxt;

  logic                            accept;
  logic                            exec_done;
  logic [dlt_pkg::IFACE_W-1:0]     in_iface;
  logic [IDX_W-1:0]                idx;
  logic [MASK_EXT-1:0]             mask_ext;
  logic                            present;
  logic [dlt_pkg::ENTRY_W-1:0]     ram_rdata;
  dlt_pkg::entry_t                 ent_cur;
  dlt_pkg::entry_t                 ent_new;
  logic                            upd_we;
  logic                            ram_we;
  dlt_pkg::result_t                upd_res;

  assign in_iface  = in_tdata[3:0];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  // The result register is free when empty or being drained this cycle.
  assign exec_done = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  assign idx      = iface_r[IDX_W-1:0];
  assign mask_ext = {{(MASK_EXT - dlt_pkg::MASK_W){1'b0}}, mask_r};
  assign present  = mask_ext[iface_r];

  // An entry never written since reset reads as the all-zero reset entry.
  assign ent_cur = (in_range_r && valid_r[idx]) ? dlt_pkg::entry_t'(ram_rdata) : '0;

  // Only one word is in flight and its write lands before the next read,
  // so no forwarding path is needed.
  dlt_ram #(
    .WIDTH (dlt_pkg::ENTRY_W),
    .DEPTH (NUM_IFACES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ent_new),
    .re    (accept),
    .raddr (in_iface[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  dlt_update u_update (
    .cmd         (cmd_r),
    .now_secs    (now_r),
    .lease_secs  (lease_r),
    .exchange_ok (ok_r),
    .in_range    (in_range_r),
    .present     (present),
    .guard_secs  (guard_r),
    .ent_i       (ent_cur),
    .ent_o       (ent_new),
    .we_o        (upd_we),
    .res_o       (upd_res)
  );

  assign ram_we = exec_done && upd_we;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    mask_nxt      = mask_r;
    guard_nxt     = guard_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cmd_nxt       = cmd_r;
    iface_nxt     = iface_r;
    now_nxt       = now_r;
    lease_nxt     = lease_r;
    ok_nxt        = ok_r;
    in_range_nxt  = in_range_r;

    if (cfg_we) begin
      unique case (cfg_addr)
        dlt_pkg::CFG_IFACE_MASK: mask_nxt  = cfg_wdata[dlt_pkg::MASK_W-1:0];
        dlt_pkg::CFG_GUARD_SECS: guard_nxt = cfg_wdata[dlt_pkg::GUARD_W-1:0];
        default:                 mask_nxt  = mask_r;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt      = dlt_pkg::cmd_t'(in_tuser);
          iface_nxt    = in_iface;
          now_nxt      = in_tdata[35:4];
          lease_nxt    = in_tdata[67:36];
          ok_nxt       = in_tdata[68];
          in_range_nxt = 32'(in_iface) < NUM_IFACES;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = upd_res;
          state_nxt     = S_IDLE;
          if (ram_we) begin
            valid_nxt[idx] = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      mask_r      <= dlt_pkg::MASK_RESET;
      guard_r     <= dlt_pkg::GUARD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      mask_r      <= mask_nxt;
      guard_r     <= guard_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    cmd_r      <= cmd_nxt;
    iface_r    <= iface_nxt;
    now_r      <= now_nxt;
    lease_r    <= lease_nxt;
    ok_r       <= ok_nxt;
    in_range_r <= in_range_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0000000, out_data_r};

  // An accepted word always moves the sequencer into the update step.
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted word did not enter the update step");

  // Table writes happen only in the update step and only for real entries.
  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_EXEC) && in_range_r)
    else $error("table write outside the update step or out of range");

  // A finished update always leaves a result word and frees the input side.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_done |=> out_valid_r && (state_r == S_IDLE))
    else $error("update finished without a result word");

  // A written entry is marked valid from the next cycle on.
  a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> valid_r[$past(idx)])
    else $error("entry not marked valid after write");

endmodule
`default_nettype wire
